### rtl/leb_pkg.sv
// Package for the line edit buffer: line capacity, key codes, result kinds,
// and the command type passed from the front end to the back end.
// No dependencies.
`default_nettype none

package leb_pkg;

   localparam int LINE_CAPACITY = 16;
   localparam int POS_W         = $clog2(LINE_CAPACITY + 1);
   localparam int KEY_W         = 8;
   localparam int FIELD_POS_W   = 5;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KEY_W-1:0] KEY_BACKSPACE  = 8'd8;
   localparam logic [KEY_W-1:0] KEY_ENTER      = 8'd13;
   localparam logic [KEY_W-1:0] KEY_ESCAPE     = 8'd27;
   localparam logic [KEY_W-1:0] KEY_EXT_PREFIX = 8'd224;
   localparam logic [KEY_W-1:0] EXT_LEFT       = 8'd75;
   localparam logic [KEY_W-1:0] EXT_RIGHT      = 8'd77;
   localparam logic [KEY_W-1:0] EXT_HOME       = 8'd71;
   localparam logic [KEY_W-1:0] EXT_END        = 8'd79;
   localparam logic [KEY_W-1:0] PRINT_LOW      = 8'd33;
   localparam logic [KEY_W-1:0] PRINT_HIGH     = 8'd127;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_CHAR    = 2'd1,
      KIND_EMPTY   = 2'd2,
      KIND_DISCARD = 2'd3
   } leb_kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INSERT,
      OP_LEFT,
      OP_RIGHT,
      OP_HOME,
      OP_END,
      OP_BACK,
      OP_ENTER,
      OP_ESC
   } leb_op_type;

   typedef struct packed {
      leb_op_type       op;
      logic [KEY_W-1:0] key;
   } leb_cmd_type;

   typedef enum logic {
      BACK_RUN,
      BACK_EMIT
   } leb_back_state_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_INSERT,
      SHIFT_DELETE,
      SHIFT_EMIT
   } leb_shift_type;

endpackage

`default_nettype wire

### rtl/line_edit_buffer.sv
// Line edit buffer top level: front end, command queue and back end.
// Depends on leb_pkg, leb_front, leb_queue and leb_back.
// A key passes the command queue register and then the result register before its first
// result is valid. Throughput: one key per cycle for keys with one result, while results
// are taken; Enter holds the back end while the line cells shift out one character a cycle.
// Reset clears cursor, length, extended prefix, queue and result valid; line cells keep data.
`default_nettype none

module line_edit_buffer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [leb_pkg::KEY_W-1:0]     req_key_code,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [leb_pkg::KEY_W-1:0]          rsp_char_out,
   output logic [leb_pkg::FIELD_POS_W-1:0]    rsp_cursor_pos,
   output logic [leb_pkg::FIELD_POS_W-1:0]    rsp_line_len,
   output logic                               rsp_last
);
   import leb_pkg::*;

   logic        front_valid;
   logic        front_ready;
   leb_cmd_type front_cmd;
   logic        back_valid;
   logic        back_ready;
   leb_cmd_type back_cmd;

   leb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_key_code (req_key_code),
      .cmd_valid    (front_valid),
      .cmd_ready    (front_ready),
      .cmd          (front_cmd)
   );

   leb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   leb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (back_valid),
      .cmd_ready      (back_ready),
      .cmd            (back_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_char_out   (rsp_char_out),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_line_len   (rsp_line_len),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/leb_front.sv
// Front end of the line edit buffer: accepts key bytes, tracks the extended
// prefix, and classifies each key into a command. Depends on leb_pkg.
`default_nettype none

module leb_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [leb_pkg::KEY_W-1:0] req_key_code,
   output logic                           cmd_valid,
   input  wire logic                      cmd_ready,
   output leb_pkg::leb_cmd_type           cmd
);
   import leb_pkg::*;

   logic       ext_pending_ff;
   logic       ext_pending_in;
   logic       accept;
   leb_op_type op;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;

   always_comb begin
      op = OP_NONE;
      if (ext_pending_ff) begin
         unique case (req_key_code)
            EXT_LEFT:  op = OP_LEFT;
            EXT_RIGHT: op = OP_RIGHT;
            EXT_HOME:  op = OP_HOME;
            EXT_END:   op = OP_END;
            default:   op = OP_NONE;
         endcase
      end else if (req_key_code >= PRINT_LOW && req_key_code <= PRINT_HIGH) begin
         op = OP_INSERT;
      end else begin
         unique case (req_key_code)
            KEY_BACKSPACE: op = OP_BACK;
            KEY_ENTER:     op = OP_ENTER;
            KEY_ESCAPE:    op = OP_ESC;
            default:       op = OP_NONE;
         endcase
      end
   end

   assign cmd.op  = op;
   assign cmd.key = req_key_code;

   always_comb begin
      ext_pending_in = ext_pending_ff;
      if (accept) begin
         ext_pending_in = !ext_pending_ff && (req_key_code == KEY_EXT_PREFIX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_pending_ff <= 1'b0;
      end else begin
         ext_pending_ff <= ext_pending_in;
      end
   end

endmodule

`default_nettype wire

### rtl/leb_queue.sv
// Short command queue between the front end and the back end of the line
// edit buffer. Depends on leb_pkg.
`default_nettype none

module leb_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire leb_pkg::leb_cmd_type  in_cmd,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output leb_pkg::leb_cmd_type       out_cmd
);
   import leb_pkg::*;

   leb_cmd_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                push;
   logic                pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/leb_back.sv
// Back end of the line edit buffer: holds the line cells, cursor and length,
// carries out commands and drives the registered result channel.
// Depends on leb_pkg.
`default_nettype none

module leb_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   output logic                               cmd_ready,
   input  wire leb_pkg::leb_cmd_type          cmd,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [leb_pkg::KEY_W-1:0]          rsp_char_out,
   output logic [leb_pkg::FIELD_POS_W-1:0]    rsp_cursor_pos,
   output logic [leb_pkg::FIELD_POS_W-1:0]    rsp_line_len,
   output logic                               rsp_last
);
   import leb_pkg::*;

   logic [KEY_W-1:0]       store_ff [LINE_CAPACITY];
   logic [POS_W-1:0]       cursor_ff;
   logic [POS_W-1:0]       cursor_in;
   logic [POS_W-1:0]       length_ff;
   logic [POS_W-1:0]       length_in;
   logic [POS_W-1:0]       remain_ff;
   logic [POS_W-1:0]       remain_in;
   leb_back_state_type     state_ff;
   leb_back_state_type     state_in;
   leb_shift_type          shift;
   logic                   out_free;
   logic                   take;
   logic                   load;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   leb_kind_type           rsp_kind_ff;
   leb_kind_type           rsp_kind_in;
   logic [KEY_W-1:0]       rsp_char_ff;
   logic [KEY_W-1:0]       rsp_char_in;
   logic [POS_W-1:0]       rsp_cursor_ff;
   logic [POS_W-1:0]       rsp_length_ff;
   logic                   rsp_last_ff;
   logic                   rsp_last_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == BACK_RUN) && out_free;
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_RUN: begin
            if (take && cmd.op == OP_ENTER && length_ff > POS_W'(1)) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free && remain_ff == POS_W'(1)) begin
               state_in = BACK_RUN;
            end
         end
         default: state_in = BACK_RUN;
      endcase
   end

   always_comb begin
      cursor_in    = cursor_ff;
      length_in    = length_ff;
      remain_in    = remain_ff;
      shift        = SHIFT_HOLD;
      load         = 1'b0;
      rsp_kind_in  = KIND_STATUS;
      rsp_char_in  = '0;
      rsp_last_in  = 1'b1;
      unique case (state_ff)
         BACK_RUN: begin
            if (take) begin
               load = 1'b1;
               unique case (cmd.op)
                  OP_INSERT: begin
                     if (length_ff < POS_W'(LINE_CAPACITY)) begin
                        shift     = SHIFT_INSERT;
                        cursor_in = cursor_ff + 1'b1;
                        length_in = length_ff + 1'b1;
                     end
                  end
                  OP_LEFT: begin
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - 1'b1;
                     end
                  end
                  OP_RIGHT: begin
                     if (cursor_ff < length_ff) begin
                        cursor_in = cursor_ff + 1'b1;
                     end
                  end
                  OP_HOME: cursor_in = '0;
                  OP_END:  cursor_in = length_ff;
                  OP_BACK: begin
                     if (cursor_ff != '0) begin
                        shift     = SHIFT_DELETE;
                        cursor_in = cursor_ff - 1'b1;
                        length_in = length_ff - 1'b1;
                     end
                  end
                  OP_ENTER: begin
                     cursor_in = '0;
                     length_in = '0;
                     if (length_ff == '0) begin
                        rsp_kind_in = KIND_EMPTY;
                     end else begin
                        shift       = SHIFT_EMIT;
                        rsp_kind_in = KIND_CHAR;
                        rsp_char_in = store_ff[0];
                        rsp_last_in = (length_ff == POS_W'(1));
                        remain_in   = length_ff - 1'b1;
                     end
                  end
                  OP_ESC: begin
                     cursor_in   = '0;
                     length_in   = '0;
                     rsp_kind_in = KIND_DISCARD;
                  end
                  default: ;
               endcase
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               shift       = SHIFT_EMIT;
               rsp_kind_in = KIND_CHAR;
               rsp_char_in = store_ff[0];
               rsp_last_in = (remain_ff == POS_W'(1));
               remain_in   = remain_ff - 1'b1;
            end
         end
         default: ;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_RUN;
         cursor_ff    <= '0;
         length_ff    <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         length_ff    <= length_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_char_ff   <= rsp_char_in;
         rsp_cursor_ff <= cursor_in;
         rsp_length_ff <= length_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LINE_CAPACITY; i++) begin
         case (shift)
            SHIFT_INSERT: begin
               if (POS_W'(i) == cursor_ff) begin
                  store_ff[i] <= cmd.key;
               end else if (POS_W'(i) > cursor_ff) begin
                  store_ff[i] <= store_ff[(i > 0) ? i - 1 : 0];
               end
            end
            SHIFT_DELETE: begin
               if (POS_W'(i) >= cursor_ff - 1'b1) begin
                  store_ff[i] <= store_ff[(i + 1 < LINE_CAPACITY) ? i + 1 : i];
               end
            end
            SHIFT_EMIT: begin
               store_ff[i] <= store_ff[(i + 1 < LINE_CAPACITY) ? i + 1 : i];
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_char_out   = rsp_char_ff;
   assign rsp_cursor_pos = FIELD_POS_W'(rsp_cursor_ff);
   assign rsp_line_len   = FIELD_POS_W'(rsp_length_ff);
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire
